@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the prime sieve generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int unsigned MAX_LIMIT_DEF = 65535;

    localparam int VAL_W   = 16;            // prime value, index, limit
    localparam int CAND_W  = 17;            // candidate and multiple counters
    localparam int ROW_LOG = 6;             // log2 of bits per bitmap row
    localparam int ROW_BITS = 1 << ROW_LOG;

    localparam logic [VAL_W-1:0]  LIMIT_RESET = 16'hFFFF;
    localparam logic [CAND_W-1:0] FIRST_PRIME = 17'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_CHECK,
        ST_MARK,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

endpackage

@@ rtl/core/psg_if.sv @@
// ----------------------------------------------------------------------------
// psg_if
// Valid/ready channels of the prime sieve generator: request, result, config.
// ----------------------------------------------------------------------------
interface psg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface psg_res_if;
    logic                        valid;
    logic                        ready;
    logic [psg_pkg::VAL_W-1:0]   prime_value;
    logic [psg_pkg::VAL_W-1:0]   prime_index;
    logic                        done_res;

    modport source (output valid, output prime_value, output prime_index,
                    output done_res, input ready);
    modport sink   (input valid, input prime_value, input prime_index,
                    input done_res, output ready);
endinterface

interface psg_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [psg_pkg::VAL_W-1:0]   upper_limit;

    modport source (output valid, output upper_limit, input ready);
    modport sink   (input valid, input upper_limit, output ready);
endinterface

@@ rtl/core/psg_bitmap_ram.sv @@
// ----------------------------------------------------------------------------
// psg_bitmap_ram
// Simple dual-port composite bitmap store, one row per address, registered read.
// ----------------------------------------------------------------------------
module psg_bitmap_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic                 clk,
    input  psg_pkg::mem_cmd_t    cmd,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [DATA_W-1:0]    wr_data,
    output logic [DATA_W-1:0]    rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/prime_sieve_generator_top.sv @@
// ----------------------------------------------------------------------------
// prime_sieve_generator_top
// Sieve of Eratosthenes handing out one prime per request, in ascending order.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | beat taken when
//  req     | in  | restart                               | req.valid & req.ready
//  res     | out | prime_value, prime_index, done_res    | res.valid & res.ready
//  cfg     | in  | upper_limit                           | cfg.valid & cfg.ready
//
//  A request scans one candidate per cycle and marks one multiple per cycle in a
//  64-bit row buffer while its row is held; every row change stalls for a write
//  back (if dirty) and a read. Check and publish are states of their own, and a
//  marking run ends when its multiple passes the limit; the bitmap RAM port sets the pace.
//  Reset, a restart request and a limit write each run a clearing pass over all
//  MAX_LIMIT/64+1 rows (1024 by default) before the next scan.
//  A finished result sits in the output register; a new request is taken
//  meanwhile, and its result waits in the publish state until the slot frees.
// ----------------------------------------------------------------------------
module prime_sieve_generator_top #(
    parameter int unsigned MAX_LIMIT = psg_pkg::MAX_LIMIT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    psg_req_if.sink       req,
    psg_res_if.source     res,
    psg_cfg_if.sink       cfg
);

    localparam int ROWS  = int'(MAX_LIMIT / psg_pkg::ROW_BITS) + 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned LIM_CLAMP = (MAX_LIMIT < 65535) ? MAX_LIMIT : 65535;
    localparam logic [psg_pkg::VAL_W-1:0] LIM_RESET =
        (MAX_LIMIT < 65535) ? psg_pkg::VAL_W'(MAX_LIMIT) : psg_pkg::LIMIT_RESET;

    psg_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic                          pend_reg, pend_next;
    logic [psg_pkg::VAL_W-1:0]     lim_reg, lim_next;
    logic [psg_pkg::CAND_W-1:0]    cand_reg, cand_next;
    logic [psg_pkg::VAL_W-1:0]     found_reg, found_next;
    logic [psg_pkg::CAND_W-1:0]    mult_reg, mult_next;
    logic [psg_pkg::ROW_BITS-1:0]  buf_data_reg, buf_data_next;
    logic [ROW_W-1:0]              buf_row_reg, buf_row_next;
    logic                          buf_valid_reg, buf_valid_next;
    logic                          buf_dirty_reg, buf_dirty_next;
    logic [ROW_W-1:0]              fetch_row_reg, fetch_row_next;
    logic                          ret_mark_reg, ret_mark_next;
    logic                          out_valid_reg, out_valid_next;
    logic [psg_pkg::VAL_W-1:0]     out_value_reg, out_value_next;
    logic [psg_pkg::VAL_W-1:0]     out_index_reg, out_index_next;
    logic                          out_done_reg, out_done_next;

    psg_pkg::mem_cmd_t             mem_cmd;
    logic [ROW_W-1:0]              mem_rd_addr;
    logic [ROW_W-1:0]              mem_wr_addr;
    logic [psg_pkg::ROW_BITS-1:0]  mem_wr_data;
    logic [psg_pkg::ROW_BITS-1:0]  mem_rd_data;

    logic [psg_pkg::CAND_W-1:0]    lim_ext;
    logic [ROW_W-1:0]              cand_row, mult_row;
    logic [psg_pkg::ROW_LOG-1:0]   cand_bit, mult_bit;
    logic                          cand_over, mult_over;
    logic                          cand_hit, mult_hit;
    logic [2*psg_pkg::VAL_W-1:0]   cand_sq;
    logic                          sq_ok;
    logic                          clr_last;
    logic                          out_free;
    logic                          req_beat, cfg_beat;
    logic                          scan_miss, mark_miss;

    psg_bitmap_ram #(
        .DEPTH  (ROWS),
        .ADDR_W (ROW_W),
        .DATA_W (psg_pkg::ROW_BITS)
    ) u_ram (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign lim_ext   = {1'b0, lim_reg};
    assign cand_row  = ROW_W'(cand_reg >> psg_pkg::ROW_LOG);
    assign mult_row  = ROW_W'(mult_reg >> psg_pkg::ROW_LOG);
    assign cand_bit  = cand_reg[psg_pkg::ROW_LOG-1:0];
    assign mult_bit  = mult_reg[psg_pkg::ROW_LOG-1:0];
    assign cand_over = cand_reg > lim_ext;
    assign mult_over = mult_reg > lim_ext;
    assign cand_hit  = buf_valid_reg && (buf_row_reg == cand_row);
    assign mult_hit  = buf_valid_reg && (buf_row_reg == mult_row);
    // candidate is within the limit here, so 16 bits hold it
    assign cand_sq   = {{psg_pkg::VAL_W{1'b0}}, cand_reg[psg_pkg::VAL_W-1:0]} *
                       {{psg_pkg::VAL_W{1'b0}}, cand_reg[psg_pkg::VAL_W-1:0]};
    assign sq_ok     = cand_sq <= {{psg_pkg::VAL_W{1'b0}}, lim_reg};
    assign clr_last  = clr_cnt_reg == ROW_W'(ROWS - 1);
    assign out_free  = !out_valid_reg || res.ready;
    assign req_beat  = req.valid && req.ready;
    assign cfg_beat  = cfg.valid && cfg.ready;
    assign scan_miss = (state_reg == psg_pkg::ST_SCAN) && !cand_over && !cand_hit;
    assign mark_miss = (state_reg == psg_pkg::ST_MARK) && !mult_over && !mult_hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psg_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = pend_reg ? psg_pkg::ST_SCAN : psg_pkg::ST_IDLE;
                end
            end
            psg_pkg::ST_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = req.restart ? psg_pkg::ST_CLEAR : psg_pkg::ST_SCAN;
                end
            end
            psg_pkg::ST_SCAN:
            begin
                if (cand_over)
                begin
                    state_next = psg_pkg::ST_PUBLISH;
                end
                else if (!cand_hit)
                begin
                    state_next = psg_pkg::ST_FETCH;
                end
                else if (!buf_data_reg[cand_bit])
                begin
                    state_next = psg_pkg::ST_CHECK;
                end
            end
            psg_pkg::ST_FETCH:
            begin
                state_next = ret_mark_reg ? psg_pkg::ST_MARK : psg_pkg::ST_SCAN;
            end
            psg_pkg::ST_CHECK:
            begin
                state_next = sq_ok ? psg_pkg::ST_MARK : psg_pkg::ST_PUBLISH;
            end
            psg_pkg::ST_MARK:
            begin
                if (mult_over)
                begin
                    state_next = psg_pkg::ST_PUBLISH;
                end
                else if (!mult_hit)
                begin
                    state_next = psg_pkg::ST_FETCH;
                end
            end
            psg_pkg::ST_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = psg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psg_pkg::ST_CLEAR;
            end
        endcase
        if (cfg_beat)
        begin
            state_next = psg_pkg::ST_CLEAR;
        end
    end

    // outputs: handshake and bitmap port
    always_comb
    begin
        req.ready     = state_reg == psg_pkg::ST_IDLE;
        cfg.ready     = 1'b1;
        mem_cmd.rd_en = scan_miss || mark_miss;
        mem_cmd.wr_en = (state_reg == psg_pkg::ST_CLEAR) ||
                        ((scan_miss || mark_miss) && buf_dirty_reg);
        mem_rd_addr   = (state_reg == psg_pkg::ST_SCAN) ? cand_row : mult_row;
        mem_wr_addr   = (state_reg == psg_pkg::ST_CLEAR) ? clr_cnt_reg : buf_row_reg;
        mem_wr_data   = (state_reg == psg_pkg::ST_CLEAR) ? '0 : buf_data_reg;
    end

    assign res.valid       = out_valid_reg;
    assign res.prime_value = out_value_reg;
    assign res.prime_index = out_index_reg;
    assign res.done_res    = out_done_reg;

    // datapath
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        pend_next      = pend_reg;
        lim_next       = lim_reg;
        cand_next      = cand_reg;
        found_next     = found_reg;
        mult_next      = mult_reg;
        buf_data_next  = buf_data_reg;
        buf_row_next   = buf_row_reg;
        buf_valid_next = buf_valid_reg;
        buf_dirty_next = buf_dirty_reg;
        fetch_row_next = fetch_row_reg;
        ret_mark_next  = ret_mark_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_done_next  = out_done_reg;

        case (state_reg)
            psg_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    pend_next = 1'b0;
                end
            end
            psg_pkg::ST_IDLE:
            begin
                if (req_beat && req.restart)
                begin
                    pend_next      = 1'b1;
                    clr_cnt_next   = '0;
                    cand_next      = psg_pkg::FIRST_PRIME;
                    found_next     = '0;
                    buf_valid_next = 1'b0;
                    buf_dirty_next = 1'b0;
                end
            end
            psg_pkg::ST_SCAN:
            begin
                if (scan_miss)
                begin
                    fetch_row_next = cand_row;
                    ret_mark_next  = 1'b0;
                    buf_dirty_next = 1'b0;
                end
                else if (!cand_over && buf_data_reg[cand_bit])
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            psg_pkg::ST_FETCH:
            begin
                buf_data_next  = mem_rd_data;
                buf_row_next   = fetch_row_reg;
                buf_valid_next = 1'b1;
                buf_dirty_next = 1'b0;
            end
            psg_pkg::ST_CHECK:
            begin
                mult_next = cand_reg << 1;
            end
            psg_pkg::ST_MARK:
            begin
                if (mark_miss)
                begin
                    fetch_row_next = mult_row;
                    ret_mark_next  = 1'b1;
                    buf_dirty_next = 1'b0;
                end
                else if (!mult_over)
                begin
                    buf_data_next[mult_bit] = 1'b1;
                    buf_dirty_next          = 1'b1;
                    mult_next               = mult_reg + cand_reg;
                end
            end
            psg_pkg::ST_PUBLISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = found_reg;
                    out_done_next  = cand_over;
                    out_value_next = cand_over ? '0 : cand_reg[psg_pkg::VAL_W-1:0];
                    if (!cand_over)
                    begin
                        found_next = found_reg + 1'b1;
                        cand_next  = cand_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                clr_cnt_next = '0;
            end
        endcase

        // a limit write restarts the sieve
        if (cfg_beat)
        begin
            lim_next       = (32'(cfg.upper_limit) > LIM_CLAMP) ?
                             psg_pkg::VAL_W'(LIM_CLAMP) : cfg.upper_limit;
            clr_cnt_next   = '0;
            cand_next      = psg_pkg::FIRST_PRIME;
            found_next     = '0;
            buf_valid_next = 1'b0;
            buf_dirty_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psg_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            lim_reg       <= LIM_RESET;
            cand_reg      <= psg_pkg::FIRST_PRIME;
            found_reg     <= '0;
            buf_valid_reg <= 1'b0;
            buf_dirty_reg <= 1'b0;
            ret_mark_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            lim_reg       <= lim_next;
            cand_reg      <= cand_next;
            found_reg     <= found_next;
            buf_valid_reg <= buf_valid_next;
            buf_dirty_reg <= buf_dirty_next;
            ret_mark_reg  <= ret_mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg      <= mult_next;
        buf_data_reg  <= buf_data_next;
        buf_row_reg   <= buf_row_next;
        fetch_row_reg <= fetch_row_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_done_reg  <= out_done_next;
    end

endmodule

@@ rtl/core/psg_checker.sv @@
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks of the prime sieve generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [psg_pkg::VAL_W-1:0]   res_value,
    input logic                        res_done
);

    logic       req_beat, res_beat;
    logic [1:0] outst_reg, outst_next;

    assign req_beat = req_valid && req_ready;
    assign res_beat = res_valid && res_ready;

    // requests taken whose result beat has not gone out yet
    always_comb
    begin
        outst_next = outst_reg + {1'b0, req_beat} - {1'b0, res_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    `ASSERT_SAME(a_done_value_zero, clk, rst_n, res_valid && res_done, res_value == '0)
    `ASSERT_SAME(a_prime_at_least_two, clk, rst_n, res_valid && !res_done, res_value >= 16'd2)
    `ASSERT_SAME(a_no_extra_result, clk, rst_n, res_beat, outst_reg != 2'd0)
    `ASSERT_SAME(a_two_in_flight_max, clk, rst_n, req_beat, outst_reg <= 2'd1)
    `ASSERT_NEXT(a_res_held, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_value))

endmodule

bind prime_sieve_generator_top psg_checker u_psg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_value (res.prime_value),
    .res_done  (res.done_res)
);
